@@ rtl/spp_pkg.sv @@
// Shared types, constants and helper function of the sweep-and-prune pair emitter.
package spp_pkg;

    localparam int MAX_BODIES = 64;
    localparam int ID_W       = 6;
    localparam int NUM_IDS    = 1 << ID_W;
    localparam int S_DATA_W   = ((ID_W + 7) / 8) * 8;
    localparam int S_USER_W   = 2;
    localparam int M_DATA_W   = ((2 * ID_W + 7) / 8) * 8;

    typedef logic [ID_W-1:0]    t_id;
    typedef logic [NUM_IDS-1:0] t_bitmap;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic has_pairs;
        logic last_pair;
        logic out_free;
    } t_dp_status;

    // Index of the single set bit of a one-hot vector.
    function automatic t_id onehot_to_id(input t_bitmap onehot);
        t_id idx;
        idx = '0;
        for (int i = 0; i < NUM_IDS; i++) begin
            if (onehot[i]) begin
                idx = idx | t_id'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/spp_ctrl.sv @@
// Controller state machine of the sweep-and-prune pair emitter.
module spp_ctrl
    import spp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid && i_status.has_pairs) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_status.out_free && i_status.last_pair) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.load = i_s_tvalid;
            end
            ST_SCAN: begin
                o_cmd.emit = i_status.out_free;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/spp_datapath.sv @@
// Datapath of the sweep-and-prune pair emitter: open-body bitmap, scan mask, output register.
module spp_datapath
    import spp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    input  t_id                 i_body_id,
    input  logic                i_is_start,
    input  logic                i_frame_start,
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast
);

    t_bitmap r_open;
    t_bitmap n_open;
    t_bitmap r_scan;
    t_bitmap n_scan;
    t_id     r_new_id;
    t_id     r_first;
    t_id     r_second;
    logic    r_last;
    logic    r_out_valid;

    t_bitmap open_base;
    t_bitmap id_bit;
    t_bitmap others;
    t_bitmap low_bit;
    logic    id_ok;

    // Bitmap as seen by the incoming endpoint, after an optional frame clear.
    assign open_base = i_frame_start ? '0 : r_open;
    assign id_ok     = 32'(i_body_id) < MAX_BODIES;
    assign id_bit    = t_bitmap'(1) << i_body_id;
    assign others    = open_base & ~id_bit;

    // Lowest pending partner of the body being scanned.
    assign low_bit = r_scan & (~r_scan + t_bitmap'(1));

    assign o_status.has_pairs = id_ok && i_is_start && (others != '0);
    assign o_status.last_pair = (r_scan ^ low_bit) == '0;
    assign o_status.out_free  = !r_out_valid || i_m_tready;

    always_comb begin
        n_open = r_open;
        n_scan = r_scan;
        if (i_cmd.load) begin
            n_open = open_base;
            if (id_ok) begin
                if (i_is_start) begin
                    n_open = open_base | id_bit;
                    n_scan = others;
                end else begin
                    n_open = open_base & ~id_bit;
                end
            end
        end else if (i_cmd.emit) begin
            n_scan = r_scan ^ low_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open      <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_open <= n_open;
            r_scan <= n_scan;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new_id <= i_body_id;
        end
        if (i_cmd.emit) begin
            r_first  <= onehot_to_id(low_bit);
            r_second <= r_new_id;
            r_last   <= o_status.last_pair;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_DATA_W'({r_second, r_first});
    assign o_m_tlast  = r_last;

endmodule

@@ rtl/sweep_prune_pair_emitter_unit.sv @@
// Top level of the sweep-and-prune pair emitter: stream ports, controller and datapath.
//
// This block takes interval endpoints that are already sorted along the sweep axis, one
// per input transaction, and keeps a bitmap of the bodies whose intervals are open. A
// start endpoint produces one output transaction per body that is already open, in
// ascending id order, each carrying the pair (open body, new body), with tlast set on the
// final pair of that endpoint; the new body is then open. An end endpoint closes its body
// and produces nothing. A set frame_start flag clears the bitmap before the endpoint is
// handled. Ids at or above MAX_BODIES leave the bitmap alone and produce no pair, and a
// body never pairs with itself. Flow: an endpoint is taken whenever the controller is idle,
// and the bitmap is updated as it is taken; a start endpoint that finds other open bodies
// then keeps the input closed while the scan unit emits its pairs, one pair per cycle while
// the output side does not stall. The output register lets an endpoint be accepted while
// the last pair of the previous one is still waiting.
module sweep_prune_pair_emitter_unit
    import spp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // [5:0] body_id, upper bits zero
    input  logic [S_USER_W-1:0] i_s_tuser,  // [0] is_start, [1] frame_start
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,  // [5:0] first_body, [11:6] second_body
    output logic                o_m_tlast   // last_pair
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // The controller only moves between waiting for an endpoint and scanning its partners.
    spp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // The datapath holds the bitmap, the mask of partners still to emit and the output register.
    spp_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_body_id     (i_s_tdata[ID_W-1:0]),
        .i_is_start    (i_s_tuser[0]),
        .i_frame_start (i_s_tuser[1]),
        .o_m_tvalid    (o_m_tvalid),
        .i_m_tready    (i_m_tready),
        .o_m_tdata     (o_m_tdata),
        .o_m_tlast     (o_m_tlast)
    );

endmodule
